// ----- rtl/core/owbm_pkg.sv -----
// Types, codes and timing helpers shared by the 1-Wire bus master.
package owbm_pkg;

    localparam int TIMER_BITS = 16;
    localparam int REG_BITS = 16;
    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_RESET      = 3'd1,
        CMD_WRITE_BIT  = 3'd2,
        CMD_READ_BIT   = 3'd3,
        CMD_WRITE_BYTE = 3'd4,
        CMD_READ_BYTE  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_WRITE_LOW     = 3'd3,
        REG_WRITE_HOLD    = 3'd4,
        REG_READ_LOW      = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_TAIL     = 3'd7
    } reg_index_t;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_RST_LOW  = 9'b000000010,
        PH_RST_WAIT = 9'b000000100,
        PH_RST_TAIL = 9'b000001000,
        PH_WR_LOW   = 9'b000010000,
        PH_WR_HOLD  = 9'b000100000,
        PH_RD_LOW   = 9'b001000000,
        PH_RD_WAIT  = 9'b010000000,
        PH_RD_TAIL  = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [REG_BITS-1:0] reset_low;
        logic [REG_BITS-1:0] presence_wait;
        logic [REG_BITS-1:0] reset_tail;
        logic [REG_BITS-1:0] write_low;
        logic [REG_BITS-1:0] write_hold;
        logic [REG_BITS-1:0] read_low;
        logic [REG_BITS-1:0] read_sample;
        logic [REG_BITS-1:0] read_tail;
    } cfg_t;

    localparam cfg_t CFG_DEFAULT = '{
        reset_low:     16'd500,
        presence_wait: 16'd70,
        reset_tail:    16'd500,
        write_low:     16'd10,
        write_hold:    16'd50,
        read_low:      16'd5,
        read_sample:   16'd5,
        read_tail:     16'd50
    };

    // Tick count loaded on entry to a phase: zero counts as one, saturate to timer range.
    function automatic logic [TIMER_BITS-1:0] phase_len(cfg_t c, phase_t p);
        logic [REG_BITS-1:0] raw;
        logic [32:0] len;
        case (p)
            PH_RST_LOW:  raw = c.reset_low;
            PH_RST_WAIT: raw = c.presence_wait;
            PH_RST_TAIL: raw = c.reset_tail;
            PH_WR_LOW:   raw = c.write_low;
            PH_WR_HOLD:  raw = c.write_hold;
            PH_RD_LOW:   raw = c.read_low;
            PH_RD_WAIT:  raw = c.read_sample;
            PH_RD_TAIL:  raw = c.read_tail;
            default:     raw = REG_BITS'(1);
        endcase
        len = 33'(raw);
        if (len == 33'd0)
        begin
            len = 33'd1;
        end
        if (len > TIMER_MAX)
        begin
            len = TIMER_MAX;
        end
        return len[TIMER_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/one_wire_bus_master.sv -----
// 1-Wire bus master: tick-driven slot timing, command decode and result buffering.
//
// Each request on the slave stream is one time-base tick carrying a command, transmit
// data and the sampled bus level; each produces exactly one result on the master
// stream with the drive state, busy, done, presence and received data. A request is
// taken each clock while the skid stage is empty: the whole tick update sits between the
// request and an output register, and a one-entry skid stage takes one more request
// while the output waits; only a full skid stage holds back s_tready. Commands start only
// when idle; all phase lengths come from the eight tick-count registers, which the user
// must write through cfg_we/cfg_index/cfg_data only while the bus is idle; not enforced.
module one_wire_bus_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[2:0], tx_data[10:3], line_level[11], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // drive_low[0], busy_res[1], done_res[2], presence[3],
                                   // rx_data[11:4], zero fill
);

    localparam int TB = owbm_pkg::TIMER_BITS;

    owbm_pkg::cfg_t   cfg_reg;
    owbm_pkg::phase_t phase_reg, phase_next;
    logic [TB-1:0]    tick_count_reg, tick_count_next;
    logic [2:0]       bit_index_reg, bit_index_next;
    logic [7:0]       shift_buffer_reg, shift_buffer_next;
    logic             byte_mode_reg, byte_mode_next;
    logic             presence_flag_reg, presence_flag_next;
    logic [7:0]       receive_buffer_reg, receive_buffer_next;

    logic             out_valid_reg, skid_valid_reg;
    logic [15:0]      out_data_reg, skid_data_reg;

    owbm_pkg::cmd_t   cmd;
    logic [7:0]       tx;
    logic             line;
    logic             start;
    owbm_pkg::phase_t ph_eff;
    logic [TB-1:0]    cnt_eff;
    logic             drive;
    logic             done;
    logic             accept;
    logic             out_free;
    logic [15:0]      result;

    assign cmd  = owbm_pkg::cmd_t'(s_tdata[2:0]);
    assign tx   = s_tdata[10:3];
    assign line = s_tdata[11];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        start = 1'b0;
        if (phase_reg == owbm_pkg::PH_IDLE)
        begin
            case (cmd)
                owbm_pkg::CMD_RESET,
                owbm_pkg::CMD_WRITE_BIT,
                owbm_pkg::CMD_READ_BIT,
                owbm_pkg::CMD_WRITE_BYTE,
                owbm_pkg::CMD_READ_BYTE: start = 1'b1;
                default:                 start = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        ph_eff              = phase_reg;
        cnt_eff             = tick_count_reg;
        bit_index_next      = bit_index_reg;
        shift_buffer_next   = shift_buffer_reg;
        byte_mode_next      = byte_mode_reg;
        presence_flag_next  = presence_flag_reg;
        receive_buffer_next = receive_buffer_reg;
        drive               = 1'b0;
        done                = 1'b0;

        // command tick is the first tick of the first phase
        if (start)
        begin
            bit_index_next = 3'd0;
            byte_mode_next = (cmd == owbm_pkg::CMD_WRITE_BYTE) ||
                             (cmd == owbm_pkg::CMD_READ_BYTE);
            case (cmd)
                owbm_pkg::CMD_RESET:
                begin
                    ph_eff = owbm_pkg::PH_RST_LOW;
                end
                owbm_pkg::CMD_WRITE_BIT:
                begin
                    shift_buffer_next = {7'd0, tx[0]};
                    ph_eff = owbm_pkg::PH_WR_LOW;
                end
                owbm_pkg::CMD_WRITE_BYTE:
                begin
                    shift_buffer_next = tx;
                    ph_eff = owbm_pkg::PH_WR_LOW;
                end
                default:
                begin
                    receive_buffer_next = 8'd0;
                    ph_eff = owbm_pkg::PH_RD_LOW;
                end
            endcase
            cnt_eff = owbm_pkg::phase_len(cfg_reg, ph_eff);
        end

        phase_next      = ph_eff;
        tick_count_next = cnt_eff;

        if (ph_eff != owbm_pkg::PH_IDLE)
        begin
            case (ph_eff)
                owbm_pkg::PH_RST_LOW,
                owbm_pkg::PH_WR_LOW,
                owbm_pkg::PH_RD_LOW:  drive = 1'b1;
                owbm_pkg::PH_WR_HOLD: drive = !shift_buffer_next[bit_index_next];
                default:              drive = 1'b0;
            endcase

            if (cnt_eff != '0)
            begin
                tick_count_next = cnt_eff - TB'(1);
            end

            if (cnt_eff <= TB'(1))
            begin
                case (ph_eff)
                    owbm_pkg::PH_RST_LOW:
                    begin
                        phase_next = owbm_pkg::PH_RST_WAIT;
                    end
                    owbm_pkg::PH_RST_WAIT:
                    begin
                        presence_flag_next = !line;
                        phase_next = owbm_pkg::PH_RST_TAIL;
                    end
                    owbm_pkg::PH_RST_TAIL:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    owbm_pkg::PH_WR_LOW:
                    begin
                        phase_next = owbm_pkg::PH_WR_HOLD;
                    end
                    owbm_pkg::PH_WR_HOLD:
                    begin
                        if (byte_mode_next && (bit_index_next != 3'd7))
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next = owbm_pkg::PH_WR_LOW;
                        end
                        else
                        begin
                            phase_next = owbm_pkg::PH_IDLE;
                            done = 1'b1;
                        end
                    end
                    owbm_pkg::PH_RD_LOW:
                    begin
                        phase_next = owbm_pkg::PH_RD_WAIT;
                    end
                    owbm_pkg::PH_RD_WAIT:
                    begin
                        if (line)
                        begin
                            receive_buffer_next[bit_index_next] = 1'b1;
                        end
                        phase_next = owbm_pkg::PH_RD_TAIL;
                    end
                    owbm_pkg::PH_RD_TAIL:
                    begin
                        if (byte_mode_next && (bit_index_next != 3'd7))
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next = owbm_pkg::PH_RD_LOW;
                        end
                        else
                        begin
                            phase_next = owbm_pkg::PH_IDLE;
                            done = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                    end
                endcase

                // fresh load on phase change; idle clears the count to zero
                if ((phase_next != owbm_pkg::PH_IDLE) && (phase_next != ph_eff || done))
                begin
                    tick_count_next = owbm_pkg::phase_len(cfg_reg, phase_next);
                end
                else if (phase_next == owbm_pkg::PH_IDLE)
                begin
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = owbm_pkg::phase_len(cfg_reg, phase_next);
                end
            end
        end
    end

    assign result = {4'd0, receive_buffer_next, presence_flag_next, done,
                     (phase_next != owbm_pkg::PH_IDLE), drive};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= owbm_pkg::CFG_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (owbm_pkg::reg_index_t'(cfg_index))
                owbm_pkg::REG_RESET_LOW:     cfg_reg.reset_low     <= cfg_data;
                owbm_pkg::REG_PRESENCE_WAIT: cfg_reg.presence_wait <= cfg_data;
                owbm_pkg::REG_RESET_TAIL:    cfg_reg.reset_tail    <= cfg_data;
                owbm_pkg::REG_WRITE_LOW:     cfg_reg.write_low     <= cfg_data;
                owbm_pkg::REG_WRITE_HOLD:    cfg_reg.write_hold    <= cfg_data;
                owbm_pkg::REG_READ_LOW:      cfg_reg.read_low      <= cfg_data;
                owbm_pkg::REG_READ_SAMPLE:   cfg_reg.read_sample   <= cfg_data;
                owbm_pkg::REG_READ_TAIL:     cfg_reg.read_tail     <= cfg_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= owbm_pkg::PH_IDLE;
            tick_count_reg     <= '0;
            bit_index_reg      <= 3'd0;
            shift_buffer_reg   <= 8'd0;
            byte_mode_reg      <= 1'b0;
            presence_flag_reg  <= 1'b0;
            receive_buffer_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            bit_index_reg      <= bit_index_next;
            shift_buffer_reg   <= shift_buffer_next;
            byte_mode_reg      <= byte_mode_next;
            presence_flag_reg  <= presence_flag_next;
            receive_buffer_reg <= receive_buffer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_free)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("stalled request result not held in skid");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == owbm_pkg::PH_IDLE) |-> (tick_count_reg == '0))
        else $error("tick count left running in idle");

    a_bit_index_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_index_reg != 3'd0) |-> byte_mode_reg)
        else $error("bit index advanced outside byte mode");
`endif

endmodule
